FILE: hw/rtl/ihex_pkg.sv
`timescale 1ns / 1ps

package ihex_pkg;

    localparam int LINE_BYTES_DEF = 16;
    localparam int MAX_RESULTS    = 32;
    localparam int CNT_W          = 6;
    localparam int CMDQ_DEPTH     = 2;

    localparam logic [7:0] TYPE_DATA = 8'h00;
    localparam logic [7:0] TYPE_EOF  = 8'h01;
    localparam logic [7:0] TYPE_EXT  = 8'h04;
    localparam logic [7:0] EXT_LEN   = 8'd2;

    typedef enum logic [1:0] {
        CMD_APPEND,
        CMD_APPEND_LINE,
        CMD_FLUSH_LINE,
        CMD_FLUSH_EMPTY
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
        logic [7:0] slot;
    } cmd_t;

    typedef enum logic [2:0] {
        BE_IDLE,
        BE_LEN,
        BE_ADDR_HI,
        BE_ADDR_LO,
        BE_TYPE,
        BE_DATA,
        BE_CKSUM
    } be_state_t;

    typedef enum logic [1:0] {
        REC_DATA,
        REC_EXT,
        REC_EOF
    } rec_kind_t;

    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
        begin
            return 7'd48 + {3'b000, nib};
        end
        return 7'd55 + {3'b000, nib};
    endfunction

endpackage

FILE: hw/rtl/ihex_front.sv
`timescale 1ns / 1ps

module ihex_front
    import ihex_pkg::*;
#(
    parameter int LINE_BYTES = LINE_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       q_full,
    input  logic       operation,
    input  logic [7:0] data_byte,
    output logic       q_wr,
    output cmd_t       q_cmd
);

    logic [7:0] fill_reg;
    logic [7:0] fill_next;

    always_comb
    begin
        q_wr       = push && !q_full;
        q_cmd.data = data_byte;
        q_cmd.slot = fill_reg;
        fill_next  = fill_reg;
        if (operation)
        begin
            q_cmd.kind = (fill_reg == 8'd0) ? CMD_FLUSH_EMPTY : CMD_FLUSH_LINE;
            fill_next  = 8'd0;
        end
        else if (fill_reg == 8'(LINE_BYTES - 1))
        begin
            q_cmd.kind = CMD_APPEND_LINE;
            fill_next  = 8'd0;
        end
        else
        begin
            q_cmd.kind = CMD_APPEND;
            fill_next  = fill_reg + 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= 8'd0;
        end
        else if (q_wr)
        begin
            fill_reg <= fill_next;
        end
    end

endmodule

FILE: hw/rtl/ihex_cmd_fifo.sv
`timescale 1ns / 1ps

module ihex_cmd_fifo
    import ihex_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr,
    input  cmd_t wr_cmd,
    input  logic rd,
    output cmd_t rd_cmd,
    output logic full,
    output logic not_empty
);

    localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CNT_QW = $clog2(CMDQ_DEPTH + 1);

    cmd_t              slots_reg [CMDQ_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_QW-1:0] count_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_QW-1:0] count_next;

    assign full      = (count_reg == CNT_QW'(CMDQ_DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_cmd    = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr && !rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slots_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

FILE: hw/rtl/ihex_back.sv
`timescale 1ns / 1ps

module ihex_back
    import ihex_pkg::*;
#(
    parameter int LINE_BYTES = LINE_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  cmd_t       cmd,
    output logic       cmd_pop,
    input  logic       pop,
    output logic       empty,
    output logic       record_start,
    output logic [7:0] byte_value,
    output logic [6:0] hex_high_char,
    output logic [6:0] hex_low_char,
    output logic       record_end,
    output logic       last
);

    localparam int IDX_W = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;

    logic [7:0] line_mem [LINE_BYTES];

    be_state_t        state_reg;
    be_state_t        state_next;
    rec_kind_t        kind_reg;
    rec_kind_t        kind_next;
    logic [7:0]       len_reg;
    logic [7:0]       len_next;
    logic [7:0]       idx_reg;
    logic [7:0]       idx_next;
    logic [7:0]       sum_reg;
    logic [7:0]       sum_next;
    logic [31:0]      addr_reg;
    logic [31:0]      addr_next;
    logic             flush_reg;
    logic             flush_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_start_reg;
    logic [7:0]       out_byte_reg;
    logic [6:0]       out_hi_reg;
    logic [6:0]       out_lo_reg;
    logic             out_end_reg;
    logic             out_last_reg;
    logic [7:0]       rd_data_reg;

    logic        mem_we;
    logic        rd_en;
    logic [7:0]  rd_idx;
    logic [7:0]  cur_byte;
    logic [31:0] addr_sum;
    logic        ext_due;
    logic        final_byte;
    logic        suppress;
    logic        step;
    logic        load;
    logic        cur_last;

    assign addr_sum   = addr_reg + {24'd0, len_reg};
    assign ext_due    = (addr_sum[15:0] == 16'd0);
    assign suppress   = (cnt_reg == CNT_W'(MAX_RESULTS));
    assign step       = (state_reg != BE_IDLE) && (suppress || !out_valid_reg || pop);
    assign final_byte = (state_reg == BE_CKSUM) &&
                        ((kind_reg == REC_EOF) ||
                         (kind_reg == REC_DATA && !flush_reg && !ext_due) ||
                         (kind_reg == REC_EXT && !flush_reg));
    assign cur_last   = final_byte || (cnt_reg == CNT_W'(MAX_RESULTS - 1));

    always_comb
    begin
        case (state_reg)
            BE_LEN:     cur_byte = len_reg;
            BE_ADDR_HI: cur_byte = (kind_reg == REC_DATA) ? addr_reg[15:8] : 8'd0;
            BE_ADDR_LO: cur_byte = (kind_reg == REC_DATA) ? {addr_reg[7:4], 4'h0} : 8'd0;
            BE_TYPE:
            begin
                case (kind_reg)
                    REC_DATA: cur_byte = TYPE_DATA;
                    REC_EXT:  cur_byte = TYPE_EXT;
                    default:  cur_byte = TYPE_EOF;
                endcase
            end
            BE_DATA:
            begin
                if (kind_reg == REC_DATA)
                begin
                    cur_byte = rd_data_reg;
                end
                else
                begin
                    cur_byte = (idx_reg == 8'd0) ? addr_reg[31:24] : addr_reg[23:16];
                end
            end
            BE_CKSUM:   cur_byte = 8'd0 - sum_reg;
            default:    cur_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        addr_next  = addr_reg;
        flush_next = flush_reg;
        cnt_next   = cnt_reg;
        cmd_pop    = 1'b0;
        mem_we     = 1'b0;
        rd_en      = 1'b0;
        rd_idx     = idx_reg + 8'd1;
        load       = 1'b0;
        case (state_reg)
            BE_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop  = 1'b1;
                    cnt_next = '0;
                    case (cmd.kind)
                        CMD_APPEND:
                        begin
                            mem_we = 1'b1;
                        end
                        CMD_APPEND_LINE:
                        begin
                            mem_we     = 1'b1;
                            kind_next  = REC_DATA;
                            len_next   = 8'(LINE_BYTES);
                            flush_next = 1'b0;
                            state_next = BE_LEN;
                        end
                        CMD_FLUSH_LINE:
                        begin
                            kind_next  = REC_DATA;
                            len_next   = cmd.slot;
                            flush_next = 1'b1;
                            state_next = BE_LEN;
                        end
                        default:
                        begin
                            kind_next  = REC_EOF;
                            len_next   = 8'd0;
                            flush_next = 1'b0;
                            state_next = BE_LEN;
                        end
                    endcase
                end
            end
            default:
            begin
                if (step)
                begin
                    load     = !suppress;
                    cnt_next = suppress ? cnt_reg : cnt_reg + 1'b1;
                    sum_next = (state_reg == BE_LEN) ? cur_byte : sum_reg + cur_byte;
                    case (state_reg)
                        BE_LEN:     state_next = BE_ADDR_HI;
                        BE_ADDR_HI: state_next = BE_ADDR_LO;
                        BE_ADDR_LO: state_next = BE_TYPE;
                        BE_TYPE:
                        begin
                            idx_next   = 8'd0;
                            rd_idx     = 8'd0;
                            rd_en      = (kind_reg == REC_DATA);
                            state_next = (len_reg == 8'd0) ? BE_CKSUM : BE_DATA;
                        end
                        BE_DATA:
                        begin
                            idx_next = idx_reg + 8'd1;
                            rd_en    = (kind_reg == REC_DATA) && (idx_reg + 8'd1 < len_reg);
                            if (idx_reg + 8'd1 == len_reg)
                            begin
                                state_next = BE_CKSUM;
                            end
                        end
                        default:
                        begin
                            state_next = BE_IDLE;
                            case (kind_reg)
                                REC_DATA:
                                begin
                                    addr_next = addr_sum;
                                    if (ext_due)
                                    begin
                                        kind_next  = REC_EXT;
                                        len_next   = EXT_LEN;
                                        state_next = BE_LEN;
                                    end
                                    else if (flush_reg)
                                    begin
                                        kind_next  = REC_EOF;
                                        len_next   = 8'd0;
                                        state_next = BE_LEN;
                                    end
                                end
                                REC_EXT:
                                begin
                                    if (flush_reg)
                                    begin
                                        kind_next  = REC_EOF;
                                        len_next   = 8'd0;
                                        state_next = BE_LEN;
                                    end
                                end
                                default:
                                begin
                                    addr_next  = 32'd0;
                                    flush_next = 1'b0;
                                end
                            endcase
                        end
                    endcase
                end
            end
        endcase
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BE_IDLE;
            kind_reg      <= REC_DATA;
            len_reg       <= 8'd0;
            idx_reg       <= 8'd0;
            sum_reg       <= 8'd0;
            addr_reg      <= 32'd0;
            flush_reg     <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            len_reg       <= len_next;
            idx_reg       <= idx_next;
            sum_reg       <= sum_next;
            addr_reg      <= addr_next;
            flush_reg     <= flush_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_start_reg <= (state_reg == BE_LEN);
            out_byte_reg  <= cur_byte;
            out_hi_reg    <= hex_char(cur_byte[7:4]);
            out_lo_reg    <= hex_char(cur_byte[3:0]);
            out_end_reg   <= (state_reg == BE_CKSUM);
            out_last_reg  <= cur_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[cmd.slot[IDX_W-1:0]] <= cmd.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= line_mem[rd_idx[IDX_W-1:0]];
        end
    end

    assign empty         = !out_valid_reg;
    assign record_start  = out_start_reg;
    assign byte_value    = out_byte_reg;
    assign hex_high_char = out_hi_reg;
    assign hex_low_char  = out_lo_reg;
    assign record_end    = out_end_reg;
    assign last          = out_last_reg;

endmodule

FILE: hw/rtl/intel_hex_record_encoder_unit.sv
`timescale 1ns / 1ps
// Channel   Handshake          Word
// input     push / full        operation, data_byte
// result    pop / empty        record_start, byte_value, hex_high_char, hex_low_char,
//                              record_end, last
//
// An append that does not complete a line only writes its byte into the line buffer. A
// completed line is taken from the queue and sent as a data record, followed by an
// extended linear address record when the address crosses a 64 KiB boundary; a flush
// sends any partial line as a data record, then the end-of-file record. Reset clears
// every count and the queues. Two words wait in the input queue, so input flows until
// it is full. A stalled result holds the sequencer until an item has MAX_RESULTS words.

module intel_hex_record_encoder_unit
    import ihex_pkg::*;
#(
    parameter int LINE_BYTES = LINE_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic       operation,
    input  logic [7:0] data_byte,
    output logic       empty,
    input  logic       pop,
    output logic       record_start,
    output logic [7:0] byte_value,
    output logic [6:0] hex_high_char,
    output logic [6:0] hex_low_char,
    output logic       record_end,
    output logic       last
);

    logic q_wr;
    cmd_t q_wr_cmd;
    logic q_rd;
    cmd_t q_rd_cmd;
    logic q_not_empty;

    ihex_front #(
        .LINE_BYTES (LINE_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .q_full    (full),
        .operation (operation),
        .data_byte (data_byte),
        .q_wr      (q_wr),
        .q_cmd     (q_wr_cmd)
    );

    ihex_cmd_fifo u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (q_wr),
        .wr_cmd    (q_wr_cmd),
        .rd        (q_rd),
        .rd_cmd    (q_rd_cmd),
        .full      (full),
        .not_empty (q_not_empty)
    );

    ihex_back #(
        .LINE_BYTES (LINE_BYTES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (q_not_empty),
        .cmd           (q_rd_cmd),
        .cmd_pop       (q_rd),
        .pop           (pop),
        .empty         (empty),
        .record_start  (record_start),
        .byte_value    (byte_value),
        .hex_high_char (hex_high_char),
        .hex_low_char  (hex_low_char),
        .record_end    (record_end),
        .last          (last)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(record_start && record_end))
        else $error("A word is marked as both first and checksum byte.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last && LINE_BYTES <= 16) |-> record_end)
        else $error("The final word of an item is not a checksum byte.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (hex_high_char == hex_char(byte_value[7:4]) &&
                    hex_low_char == hex_char(byte_value[3:0])))
        else $error("The hex characters do not match the byte value.");

endmodule

FILE: dv/ihex_record_checker.sv
`timescale 1ns / 1ps

package ihex_tb_pkg;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

endpackage

module ihex_record_checker
    import ihex_pkg::*;
    import ihex_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic        operation,
    input  logic [7:0]  data_byte,
    input  logic        empty,
    input  logic        pop,
    input  logic        record_start,
    input  logic [7:0]  byte_value,
    input  logic [6:0]  hex_high_char,
    input  logic [6:0]  hex_low_char,
    input  logic        record_end,
    input  logic        last,
    output int unsigned fail_count,
    output int unsigned words_pending
);

    typedef struct packed {
        logic       start;
        logic [7:0] value;
        logic [6:0] hi_char;
        logic [6:0] lo_char;
        logic       stop;
        logic       last;
    } rec_word_t;

    rec_word_t   expected_words[$];
    rec_word_t   item_words[$];
    logic [7:0]  payload[$];
    logic [7:0]  line_buf[LINE_BYTES_DEF];
    int unsigned line_count;
    logic [31:0] byte_count;
    int unsigned errors;

    function automatic logic [6:0] ascii_digit(input logic [3:0] nib);
        return (nib < 4'd10) ? (7'h30 | {3'b000, nib}) : (7'h37 + {3'b000, nib});
    endfunction

    task automatic add_word(input logic [7:0] value, input logic start, input logic stop);
        rec_word_t w;
        w = {start, value, ascii_digit(value[7:4]), ascii_digit(value[3:0]), stop, 1'b0};
        item_words.push_back(w);
    endtask

    // Emits a whole record around the bytes waiting in payload, then empties it.
    task automatic add_record(input logic [7:0] rtype, input logic [15:0] addr);
        logic [7:0] len;
        logic [7:0] sum;
        len = 8'(payload.size());
        sum = len + addr[15:8] + addr[7:0] + rtype;
        add_word(len, 1'b1, 1'b0);
        add_word(addr[15:8], 1'b0, 1'b0);
        add_word(addr[7:0], 1'b0, 1'b0);
        add_word(rtype, 1'b0, 1'b0);
        foreach (payload[i])
        begin
            sum = sum + payload[i];
            add_word(payload[i], 1'b0, 1'b0);
        end
        add_word(8'h00 - sum, 1'b0, 1'b1);
        payload.delete();
    endtask

    task automatic close_line();
        for (int i = 0; i < line_count; i++)
        begin
            payload.push_back(line_buf[i]);
        end
        add_record(TYPE_DATA, {byte_count[15:4], 4'h0});
        byte_count = byte_count + line_count;
        line_count = 0;
        if (byte_count[15:0] == 16'h0000)
        begin
            payload.push_back(byte_count[31:24]);
            payload.push_back(byte_count[23:16]);
            add_record(TYPE_EXT, 16'h0000);
        end
    endtask

    task automatic encode_item(input logic op, input logic [7:0] value);
        rec_word_t w;
        item_words.delete();
        if (op == OP_APPEND)
        begin
            line_buf[line_count] = value;
            line_count++;
            if (line_count == LINE_BYTES_DEF)
            begin
                close_line();
            end
        end
        else
        begin
            if (line_count > 0)
            begin
                close_line();
            end
            add_record(TYPE_EOF, 16'h0000);
            line_count = 0;
            byte_count = '0;
        end
        if (item_words.size() > 0)
        begin
            w = item_words.pop_back();
            w.last = 1'b1;
            item_words.push_back(w);
        end
        foreach (item_words[i])
        begin
            expected_words.push_back(item_words[i]);
        end
    endtask

    task automatic check_word();
        rec_word_t got;
        rec_word_t want;
        got = {record_start, byte_value, hex_high_char, hex_low_char, record_end, last};
        if (expected_words.size() == 0)
        begin
            if (errors < 10)
            begin
                $display("Unexpected word: start=%0b value=%02h chars=%c%c end=%0b last=%0b",
                         got.start, got.value, got.hi_char, got.lo_char, got.stop, got.last);
            end
            errors++;
        end
        else
        begin
            want = expected_words.pop_front();
            if (got.start !== want.start || got.value !== want.value
                || got.hi_char !== want.hi_char || got.lo_char !== want.lo_char
                || got.stop !== want.stop || got.last !== want.last)
            begin
                if (errors < 10)
                begin
                    $display("Word mismatch: expected start=%0b value=%02h chars=%c%c end=%0b last=%0b",
                             want.start, want.value, want.hi_char, want.lo_char,
                             want.stop, want.last);
                    $display("               actual   start=%0b value=%02h chars=%c%c end=%0b last=%0b",
                             got.start, got.value, got.hi_char, got.lo_char,
                             got.stop, got.last);
                end
                errors++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_words.delete();
            line_count = 0;
            byte_count = '0;
            words_pending <= 0;
            fail_count <= errors;
        end
        else
        begin
            if (pop && !empty)
            begin
                check_word();
            end
            if (push && !full)
            begin
                encode_item(operation, data_byte);
            end
            words_pending <= expected_words.size();
            fail_count <= errors;
        end
    end

    initial
    begin
        errors = 0;
        line_count = 0;
        byte_count = '0;
    end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import ihex_pkg::*;
    import ihex_tb_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 130;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        operation = OP_APPEND;
    logic [7:0]  data_byte = 8'h00;
    logic        empty;
    logic        pop = 1'b0;
    logic        record_start;
    logic [7:0]  byte_value;
    logic [6:0]  hex_high_char;
    logic [6:0]  hex_low_char;
    logic        record_end;
    logic        last;
    logic        steady = 1'b0;
    int unsigned fail_count;
    int unsigned words_pending;
    int unsigned quiet_cycles = 0;

    intel_hex_record_encoder_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .operation     (operation),
        .data_byte     (data_byte),
        .empty         (empty),
        .pop           (pop),
        .record_start  (record_start),
        .byte_value    (byte_value),
        .hex_high_char (hex_high_char),
        .hex_low_char  (hex_low_char),
        .record_end    (record_end),
        .last          (last)
    );

    ihex_record_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .operation     (operation),
        .data_byte     (data_byte),
        .empty         (empty),
        .pop           (pop),
        .record_start  (record_start),
        .byte_value    (byte_value),
        .hex_high_char (hex_high_char),
        .hex_low_char  (hex_low_char),
        .record_end    (record_end),
        .last          (last),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            pop <= steady || ($urandom_range(99) >= 25);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(input logic op, input logic [7:0] value);
        while (!steady && $urandom_range(99) < 25)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        operation <= op;
        data_byte <= value;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // An end-of-file record alone, then a full line holding both byte extremes.
        send_word(OP_FLUSH, 8'hFF);
        send_word(OP_APPEND, 8'h00);
        send_word(OP_APPEND, 8'hFF);
        for (int n = 0; n < LINE_BYTES_DEF - 2; n++)
        begin
            send_word(OP_APPEND, 8'($urandom_range(255)));
        end
        send_word(OP_FLUSH, 8'h00);
        send_word(OP_APPEND, 8'h7F);
        send_word(OP_APPEND, 8'h80);
        send_word(OP_FLUSH, 8'h5A);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady <= (n >= 50 && n < 100);
            send_word(($urandom_range(15) == 0) ? OP_FLUSH : OP_APPEND,
                      8'($urandom_range(255)));
        end
        steady <= 1'b0;
        send_word(OP_FLUSH, 8'($urandom_range(255)));
        push <= 1'b0;

        @(posedge clk);
        while (words_pending != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/ihex_pkg.sv
hw/rtl/ihex_front.sv
hw/rtl/ihex_cmd_fifo.sv
hw/rtl/ihex_back.sv
hw/rtl/intel_hex_record_encoder_unit.sv
dv/ihex_record_checker.sv
dv/tb.sv
